// ----- src/ppjs_pkg.sv -----
// ----------------------------------------------------------------------------
// ppjs_pkg
// Shared types and codes for the preemptive priority job scheduler.
// ----------------------------------------------------------------------------
package ppjs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SERIAL_BITS_DEF = 32;
  localparam int IO_SERIAL_W     = 32;
  localparam int NUM_SLOTS       = 3;

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_STATUS   = 2'd2,
    OP_ACTIVITY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_ACCEPTED = 3'd0,
    K_START    = 3'd1,
    K_CANCEL   = 3'd2,
    K_ACTIVITY = 3'd3,
    K_STATUS   = 3'd4,
    K_FULL     = 3'd5
  } kind_t;

  localparam logic [1:0] ACT_PENDING = 2'd0;
  localparam logic [1:0] ACT_SUCCESS = 2'd2;
  localparam logic [1:0] ACT_FAILED  = 2'd3;

  localparam logic [1:0] PRIO_HIGH = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_FIND_SER,
    S_SHUP,
    S_SHDN,
    S_HEAD,
    S_DONE
  } state_t;

  typedef struct packed {
    kind_t                  kind;
    logic [IO_SERIAL_W-1:0] serial;
    logic [1:0]             act;
    logic                   rerr;
  } res_t;

  // engine -> result buffer
  typedef struct packed {
    logic [NUM_SLOTS-1:0] wen;
    res_t [NUM_SLOTS-1:0] data;
    logic                 go;
    logic [1:0]           n;
  } rb_ctl_t;

endpackage

// ----- src/ppjs_res_buf.sv -----
// ----------------------------------------------------------------------------
// ppjs_res_buf
// Result slots for one request, drained in order into the output register.
// ----------------------------------------------------------------------------
module ppjs_res_buf (
  input  logic              clk,
  input  logic              rst,
  input  ppjs_pkg::rb_ctl_t ctl,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output ppjs_pkg::res_t    out_res,
  output logic              last
);

  ppjs_pkg::res_t slot [ppjs_pkg::NUM_SLOTS];
  logic [1:0]     n_q;
  logic [1:0]     e_q;
  logic           load_out;
  logic           is_last;

  assign load_out = busy && (!out_valid || out_ready);
  assign is_last  = (e_q == n_q - 2'd1);

  always_ff @(posedge clk) begin
    for (int i = 0; i < ppjs_pkg::NUM_SLOTS; i++) begin
      if (ctl.wen[i]) begin
        slot[i] <= ctl.data[i];
      end
    end
    if (load_out) begin
      out_res <= slot[e_q];
      last    <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      n_q       <= 2'd0;
      e_q       <= 2'd0;
    end else begin
      if (ctl.go) begin
        n_q  <= ctl.n;
        e_q  <= 2'd0;
        busy <= (ctl.n != 2'd0);
      end else if (load_out) begin
        e_q <= e_q + 2'd1;
        if (is_last) begin
          busy <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/preemptive_priority_job_scheduler.sv -----
// ----------------------------------------------------------------------------
// preemptive_priority_job_scheduler
// One running job, a priority-ordered wait queue in RAM, preemption on submit.
// ----------------------------------------------------------------------------
// With no queue walk a request passes S_DECODE and S_DONE, then the result buffer.
// One request at a time: in_ready is low until the walk and result drain end. A
//   submit scans and shifts the queue up (requeueing the running job first when
//   needed), a cancel by serial scans and shifts down, a completion that starts
//   the queue head shifts down; walks go through the single read / single write port of the queue RAM.
// Reset: clears running job, queue count and serial counter; queue RAM holds
//   no reset value, entries at or above the count are never used.
module preemptive_priority_job_scheduler #(
  parameter int QUEUE_DEPTH = ppjs_pkg::QUEUE_DEPTH_DEF,
  parameter int SERIAL_BITS = ppjs_pkg::SERIAL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           opcode,
  input  logic [1:0]                           priority_req,
  input  logic [ppjs_pkg::IO_SERIAL_W-1:0]     job_serial,
  input  logic [1:0]                           activity,
  input  logic                                 reset_error,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           kind,
  output logic [ppjs_pkg::IO_SERIAL_W-1:0]     out_serial,
  output logic [1:0]                           out_activity,
  output logic                                 out_reset_error,
  output logic                                 last
);

  localparam int IW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int EW   = SERIAL_BITS + 2;
  localparam int CMPW = (SERIAL_BITS > ppjs_pkg::IO_SERIAL_W) ? SERIAL_BITS
                                                              : ppjs_pkg::IO_SERIAL_W;

  // serial as seen on the ports: low 32 bits, zero extended when narrower
  function automatic logic [ppjs_pkg::IO_SERIAL_W-1:0] to_io(
    input logic [SERIAL_BITS-1:0] s
  );
    logic [CMPW-1:0] e;
    e = CMPW'(s);
    return e[ppjs_pkg::IO_SERIAL_W-1:0];
  endfunction

  function automatic ppjs_pkg::res_t mk_res(
    input ppjs_pkg::kind_t                  k,
    input logic [ppjs_pkg::IO_SERIAL_W-1:0] s,
    input logic [1:0]                       a,
    input logic                             r
  );
    ppjs_pkg::res_t t;
    t.kind   = k;
    t.serial = s;
    t.act    = a;
    t.rerr   = r;
    return t;
  endfunction

  // control
  ppjs_pkg::state_t state, state_next;

  // captured request
  ppjs_pkg::op_t                     op_q;
  logic [1:0]                        pr_q;
  logic [1:0]                        act_q;
  logic [ppjs_pkg::IO_SERIAL_W-1:0]  js_q;
  logic                              re_q;

  // scheduler state
  logic [CW-1:0]          count;
  logic                   run_valid;
  logic [SERIAL_BITS-1:0] run_serial;
  logic [1:0]             run_prio;
  logic                   run_rerr;
  logic                   run_requeued;
  logic [SERIAL_BITS-1:0] serial_ctr;

  // sweep working registers
  logic [CW-1:0] idx;       // next read (scan / shift down) or next read + 1 (shift up)
  logic [CW-1:0] pos;       // insert position
  logic          rd_pend;   // rd_data holds entry rd_idx
  logic [IW-1:0] rd_idx;
  logic          ins_run;   // current insert is the preempted running job
  logic [1:0]    res_n;

  // queue RAM: {priority, serial}
  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // decode helpers
  logic                   in_fire;
  logic [1:0]             pr_in;
  logic [SERIAL_BITS-1:0] ser_new;
  logic                   match;
  logic                   preempt;
  logic                   need_two;
  logic [CW:0]            need_total;
  logic                   q_full;
  logic                   job_done;
  logic [1:0]             rd_prio;
  logic [SERIAL_BITS-1:0] rd_ser;
  logic                   find_hit;
  logic                   ser_hit;
  logic                   scan_more;
  logic                   scan_end;
  logic                   shup_more;
  logic                   shup_end;
  logic [EW-1:0]          ins_data;

  ppjs_pkg::rb_ctl_t rb_ctl;
  logic              rb_busy;
  ppjs_pkg::res_t    out_res;

  assign in_fire = in_valid && in_ready;
  assign in_ready = (state == ppjs_pkg::S_IDLE) && !rb_busy;
  assign pr_in   = (priority_req > ppjs_pkg::PRIO_HIGH) ? ppjs_pkg::PRIO_HIGH : priority_req;

  assign ser_new    = serial_ctr + 1'b1;
  assign match      = run_valid && (CMPW'(run_serial) == CMPW'(js_q));
  assign preempt    = pr_q > run_prio;
  assign need_two   = preempt && !run_requeued;
  assign need_total = {1'b0, count} + (CW+1)'(1) + (CW+1)'(need_two);
  assign q_full     = need_total > (CW+1)'(QUEUE_DEPTH);
  assign job_done   = act_q inside {ppjs_pkg::ACT_SUCCESS, ppjs_pkg::ACT_FAILED};

  assign rd_prio   = rd_data[EW-1 -: 2];
  assign rd_ser    = rd_data[SERIAL_BITS-1:0];
  assign find_hit  = rd_pend && (rd_prio < pr_q);
  assign ser_hit   = rd_pend && (CMPW'(rd_ser) == CMPW'(js_q));
  assign scan_more = idx < count;
  assign scan_end  = !rd_pend && !scan_more;
  assign shup_more = idx > pos;
  assign shup_end  = !rd_pend && !shup_more;
  // a requeued job goes in first, then the new job (serial_ctr already bumped)
  assign ins_data  = ins_run ? {run_prio, run_serial} : {pr_q, serial_ctr};

  // queue RAM, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ppjs_pkg::S_IDLE: begin
        if (in_fire) state_next = ppjs_pkg::S_DECODE;
      end
      ppjs_pkg::S_DECODE: begin
        case (op_q)
          ppjs_pkg::OP_SUBMIT: begin
            if (!run_valid || q_full) state_next = ppjs_pkg::S_DONE;
            else if (need_two)        state_next = ppjs_pkg::S_SHUP;
            else                      state_next = ppjs_pkg::S_FIND;
          end
          ppjs_pkg::OP_CANCEL: begin
            state_next = match ? ppjs_pkg::S_DONE : ppjs_pkg::S_FIND_SER;
          end
          ppjs_pkg::OP_ACTIVITY: begin
            if (match && job_done && !run_rerr && (count != '0))
              state_next = ppjs_pkg::S_HEAD;
            else
              state_next = ppjs_pkg::S_DONE;
          end
          default: state_next = ppjs_pkg::S_DONE;
        endcase
      end
      ppjs_pkg::S_FIND: begin
        if (find_hit || scan_end) state_next = ppjs_pkg::S_SHUP;
      end
      ppjs_pkg::S_FIND_SER: begin
        if (ser_hit)       state_next = ppjs_pkg::S_SHDN;
        else if (scan_end) state_next = ppjs_pkg::S_DONE;
      end
      ppjs_pkg::S_SHUP: begin
        if (shup_end) state_next = ins_run ? ppjs_pkg::S_FIND : ppjs_pkg::S_DONE;
      end
      ppjs_pkg::S_SHDN: begin
        if (scan_end) state_next = ppjs_pkg::S_DONE;
      end
      ppjs_pkg::S_HEAD: state_next = ppjs_pkg::S_SHDN;
      ppjs_pkg::S_DONE: state_next = ppjs_pkg::S_IDLE;
      default:          state_next = ppjs_pkg::S_IDLE;
    endcase
  end

  // RAM port control and result slot writes
  always_comb begin
    rd_addr = idx[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    rb_ctl  = '0;
    case (state)
      ppjs_pkg::S_DECODE: begin
        rd_addr = '0;  // queue head, used by a completion
        case (op_q)
          ppjs_pkg::OP_SUBMIT: begin
            if (!run_valid) begin
              rb_ctl.wen     = 3'b111;
              rb_ctl.data[0] = mk_res(ppjs_pkg::K_START, to_io(ser_new), 2'b00, 1'b0);
              rb_ctl.data[1] = mk_res(ppjs_pkg::K_ACTIVITY, to_io(ser_new),
                                      ppjs_pkg::ACT_PENDING, 1'b0);
              rb_ctl.data[2] = mk_res(ppjs_pkg::K_ACCEPTED, to_io(ser_new), 2'b00, 1'b0);
            end else if (q_full) begin
              rb_ctl.wen[0]  = 1'b1;
              rb_ctl.data[0] = mk_res(ppjs_pkg::K_FULL, '0, 2'b00, 1'b0);
            end else if (preempt) begin
              rb_ctl.wen     = 3'b111;
              rb_ctl.data[0] = mk_res(ppjs_pkg::K_CANCEL, to_io(run_serial), 2'b00, 1'b0);
              rb_ctl.data[1] = mk_res(ppjs_pkg::K_ACTIVITY, to_io(ser_new),
                                      ppjs_pkg::ACT_PENDING, 1'b0);
              rb_ctl.data[2] = mk_res(ppjs_pkg::K_ACCEPTED, to_io(ser_new), 2'b00, 1'b0);
            end else begin
              rb_ctl.wen     = 3'b011;
              rb_ctl.data[0] = mk_res(ppjs_pkg::K_ACTIVITY, to_io(ser_new),
                                      ppjs_pkg::ACT_PENDING, 1'b0);
              rb_ctl.data[1] = mk_res(ppjs_pkg::K_ACCEPTED, to_io(ser_new), 2'b00, 1'b0);
            end
          end
          ppjs_pkg::OP_CANCEL: begin
            if (match) begin
              rb_ctl.wen[0]  = 1'b1;
              rb_ctl.data[0] = mk_res(ppjs_pkg::K_CANCEL, to_io(run_serial), 2'b00, 1'b0);
            end
          end
          ppjs_pkg::OP_STATUS: begin
            if (match) begin
              rb_ctl.wen[0]  = 1'b1;
              rb_ctl.data[0] = mk_res(ppjs_pkg::K_STATUS, js_q, 2'b00, re_q);
            end
          end
          ppjs_pkg::OP_ACTIVITY: begin
            if (match) begin
              rb_ctl.wen[0] = 1'b1;
              if (job_done && run_rerr)
                rb_ctl.data[0] = mk_res(ppjs_pkg::K_START, to_io(run_serial), 2'b00, 1'b0);
              else if (job_done && run_requeued)
                rb_ctl.data[0] = mk_res(ppjs_pkg::K_ACTIVITY, to_io(run_serial),
                                        ppjs_pkg::ACT_PENDING, 1'b0);
              else
                rb_ctl.data[0] = mk_res(ppjs_pkg::K_ACTIVITY, to_io(run_serial), act_q, 1'b0);
            end
          end
          default: ;
        endcase
      end
      ppjs_pkg::S_FIND_SER: begin
        if (ser_hit) begin
          rb_ctl.wen[0]  = 1'b1;
          rb_ctl.data[0] = mk_res(ppjs_pkg::K_ACTIVITY, js_q, ppjs_pkg::ACT_FAILED, 1'b0);
        end
      end
      ppjs_pkg::S_SHUP: begin
        // walk down from the tail, each entry moves up by one
        rd_addr = IW'(idx - 1'b1);
        if (rd_pend) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx + 1'b1;
        end else if (shup_end) begin
          wr_en   = 1'b1;
          wr_addr = pos[IW-1:0];
          wr_data = ins_data;
        end
      end
      ppjs_pkg::S_SHDN: begin
        // walk up from the hole, each entry moves down by one
        if (rd_pend) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx - 1'b1;
        end
      end
      ppjs_pkg::S_HEAD: begin
        rb_ctl.wen[1]  = 1'b1;
        rb_ctl.data[1] = mk_res(ppjs_pkg::K_START, to_io(rd_ser), 2'b00, 1'b0);
      end
      ppjs_pkg::S_DONE: begin
        rb_ctl.go = 1'b1;
        rb_ctl.n  = res_n;
      end
      default: ;
    endcase
  end

  // captured request, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q  <= ppjs_pkg::op_t'(opcode);
      pr_q  <= pr_in;
      js_q  <= job_serial;
      act_q <= activity;
      re_q  <= reset_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ppjs_pkg::S_IDLE;
      count        <= '0;
      run_valid    <= 1'b0;
      run_serial   <= '0;
      run_prio     <= 2'd0;
      run_rerr     <= 1'b0;
      run_requeued <= 1'b0;
      serial_ctr   <= '0;
      idx          <= '0;
      pos          <= '0;
      rd_pend      <= 1'b0;
      rd_idx       <= '0;
      ins_run      <= 1'b0;
      res_n        <= 2'd0;
    end else begin
      state <= state_next;
      case (state)
        ppjs_pkg::S_DECODE: begin
          // a requeue walks up from the tail, every other sweep starts at the head
          idx     <= (op_q == ppjs_pkg::OP_SUBMIT && run_valid && !q_full && need_two)
                     ? count : '0;
          rd_pend <= 1'b0;
          case (op_q)
            ppjs_pkg::OP_SUBMIT: begin
              if (!run_valid) begin
                serial_ctr   <= ser_new;
                run_valid    <= 1'b1;
                run_serial   <= ser_new;
                run_prio     <= pr_q;
                run_rerr     <= 1'b0;
                run_requeued <= 1'b0;
                res_n        <= 2'd3;
              end else if (q_full) begin
                res_n <= 2'd1;
              end else begin
                serial_ctr <= ser_new;
                res_n      <= preempt ? 2'd3 : 2'd2;
                if (need_two) begin
                  // running job goes back to the head of the queue
                  run_requeued <= 1'b1;
                  ins_run      <= 1'b1;
                  pos          <= '0;
                end
              end
            end
            ppjs_pkg::OP_CANCEL: begin
              res_n <= {1'b0, match};
            end
            ppjs_pkg::OP_STATUS: begin
              res_n <= {1'b0, match};
              if (match) run_rerr <= re_q;
            end
            ppjs_pkg::OP_ACTIVITY: begin
              // a completion that starts the queue head adds a second result
              res_n <= (match && job_done && !run_rerr && (count != '0))
                       ? 2'd2 : {1'b0, match};
              if (match && job_done && !run_rerr) begin
                run_valid    <= 1'b0;
                run_requeued <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        ppjs_pkg::S_FIND: begin
          if (find_hit) begin
            pos     <= CW'(rd_idx);
            idx     <= count;
            rd_pend <= 1'b0;
          end else if (scan_end) begin
            pos     <= count;
            idx     <= count;
            rd_pend <= 1'b0;
          end else if (scan_more) begin
            rd_pend <= 1'b1;
            rd_idx  <= idx[IW-1:0];
            idx     <= idx + 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
        end
        ppjs_pkg::S_FIND_SER: begin
          if (ser_hit) begin
            res_n   <= 2'd1;
            idx     <= CW'(rd_idx) + 1'b1;
            rd_pend <= 1'b0;
          end else if (scan_more) begin
            rd_pend <= 1'b1;
            rd_idx  <= idx[IW-1:0];
            idx     <= idx + 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
        end
        ppjs_pkg::S_SHDN: begin
          if (scan_more) begin
            rd_pend <= 1'b1;
            rd_idx  <= idx[IW-1:0];
            idx     <= idx + 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (scan_end) begin
            count <= count - 1'b1;
          end
        end
        ppjs_pkg::S_SHUP: begin
          if (shup_more) begin
            rd_pend <= 1'b1;
            rd_idx  <= IW'(idx - 1'b1);
            idx     <= idx - 1'b1;
          end else if (shup_end && ins_run) begin
            ins_run <= 1'b0;
            idx     <= '0;
            rd_pend <= 1'b0;
          end else begin
            rd_pend <= 1'b0;
          end
          if (shup_end) begin
            count <= count + 1'b1;
          end
        end
        ppjs_pkg::S_HEAD: begin
          run_valid    <= 1'b1;
          run_serial   <= rd_ser;
          run_prio     <= rd_prio;
          run_rerr     <= 1'b0;
          run_requeued <= 1'b0;
          idx          <= CW'(1);
          rd_pend      <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  ppjs_res_buf u_res_buf (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rb_ctl),
    .busy      (rb_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .last      (last)
  );

  assign kind            = out_res.kind;
  assign out_serial      = out_res.serial;
  assign out_activity    = out_res.act;
  assign out_reset_error = out_res.rerr;

  // waiting jobs only exist behind a running job
  a_queue_needs_runner: assert property (@(posedge clk) disable iff (rst)
    (state == ppjs_pkg::S_IDLE && count != '0) |-> run_valid)
    else $error("queue holds jobs with no running job");

  a_requeue_needs_runner: assert property (@(posedge clk) disable iff (rst)
    (state == ppjs_pkg::S_IDLE && run_requeued) |-> run_valid)
    else $error("requeued mark set with no running job");

  a_count_stable_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ppjs_pkg::S_IDLE && !in_fire) |=> $stable(count))
    else $error("queue count moved while idle");

  a_serial_only_on_decode: assert property (@(posedge clk) disable iff (rst)
    (state != ppjs_pkg::S_DECODE) |=> $stable(serial_ctr))
    else $error("serial counter moved outside decode");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the preemptive priority job scheduler. Requests go
// in through a bursty sender; a scoreboard model of the wait queue and the
// running job predicts every notice, and each notice taken from the block is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int          QDEPTH       = 16;
  localparam int          DRAIN_CYCLES = 120;   // covers the longest queue walk
  localparam int          RANDOM_REQS  = 210;
  localparam logic [1:0]  PRIO_LOW     = 2'd0;
  localparam logic [1:0]  PRIO_NORMAL  = 2'd1;
  localparam logic [1:0]  PRIO_OVER    = 2'd3;  // out of range, acts as high
  localparam logic [1:0]  ACT_RUNNING  = 2'd1;

  // one predicted notice
  typedef struct {
    ppjs_pkg::kind_t kind;
    logic [31:0]     serial;
    logic [1:0]      act;
    logic            rerr;
    logic            fin;
  } notice_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [1:0]  priority_req;
  logic [31:0] job_serial;
  logic [1:0]  activity;
  logic        reset_error;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [31:0] out_serial;
  logic [1:0]  out_activity;
  logic        out_reset_error;
  logic        last;

  // scoreboard copy of the scheduler state
  logic [31:0] q_ser [QDEPTH];
  logic [1:0]  q_pri [QDEPTH];
  int          q_len;
  logic        run_on;
  logic [31:0] run_ser;
  logic [1:0]  run_pri;
  logic        run_rerr;
  logic        run_reqd;
  logic [31:0] serial_ctr;

  notice_t     due_notices[$];
  int          mismatches;
  int          burst_left;

  preemptive_priority_job_scheduler dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .priority_req    (priority_req),
    .job_serial      (job_serial),
    .activity        (activity),
    .reset_error     (reset_error),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .out_serial      (out_serial),
    .out_activity    (out_activity),
    .out_reset_error (out_reset_error),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop. Worst case is ~300 requests, each with a queue walk plus three
  // notices under long stalls; this is several times that.
  initial begin
    #10_000_000;
    $display("** preemptive_priority_job_scheduler: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard model
  // ---------------------------------------------------------------------------
  function automatic void post(ppjs_pkg::kind_t k, logic [31:0] s, logic [1:0] a,
                               logic r);
    notice_t n;
    n.kind   = k;
    n.serial = s;
    n.act    = a;
    n.rerr   = r;
    n.fin    = 1'b0;
    due_notices.push_back(n);
  endfunction

  function automatic void queue_insert(int pos, logic [31:0] s, logic [1:0] p);
    int i;
    for (i = q_len; i > pos; i--) begin
      q_ser[i] = q_ser[i-1];
      q_pri[i] = q_pri[i-1];
    end
    q_ser[pos] = s;
    q_pri[pos] = p;
    q_len++;
  endfunction

  function automatic void queue_remove(int pos);
    int i;
    for (i = pos; i + 1 < q_len; i++) begin
      q_ser[i] = q_ser[i+1];
      q_pri[i] = q_pri[i+1];
    end
    q_len--;
  endfunction

  function automatic void start_job(logic [31:0] s, logic [1:0] p);
    run_on   = 1'b1;
    run_ser  = s;
    run_pri  = p;
    run_rerr = 1'b0;
    run_reqd = 1'b0;
  endfunction

  // Advances the model by one accepted request and queues its notices.
  function automatic void predict_request(ppjs_pkg::op_t op, logic [1:0] pr_in,
                                          logic [31:0] js, logic [1:0] act, logic re);
    logic [1:0]  pr;
    logic [31:0] head_ser;
    logic [1:0]  head_pri;
    logic        hit;
    logic        preempt;
    logic        found;
    int          need;
    int          pos;
    int          first;
    int          i;
    pr    = (pr_in > ppjs_pkg::PRIO_HIGH) ? ppjs_pkg::PRIO_HIGH : pr_in;
    hit   = run_on && (run_ser == js);
    first = due_notices.size();
    case (op)
      ppjs_pkg::OP_SUBMIT: begin
        if (!run_on) begin
          // idle: start right away
          serial_ctr = serial_ctr + 1;
          start_job(serial_ctr, pr);
          post(ppjs_pkg::K_START, serial_ctr, '0, 1'b0);
          post(ppjs_pkg::K_ACTIVITY, serial_ctr, ppjs_pkg::ACT_PENDING, 1'b0);
          post(ppjs_pkg::K_ACCEPTED, serial_ctr, '0, 1'b0);
        end else begin
          preempt = (pr > run_pri);
          need    = (preempt && !run_reqd) ? 2 : 1;
          if (q_len + need > QDEPTH) begin
            post(ppjs_pkg::K_FULL, '0, '0, 1'b0);
          end else begin
            serial_ctr = serial_ctr + 1;
            if (preempt) begin
              post(ppjs_pkg::K_CANCEL, run_ser, '0, 1'b0);
              // a job already put back is not queued twice
              if (!run_reqd) begin
                queue_insert(0, run_ser, run_pri);
                run_reqd = 1'b1;
              end
            end
            pos = q_len;
            for (i = q_len - 1; i >= 0; i--) begin
              if (q_pri[i] < pr) pos = i;
            end
            queue_insert(pos, serial_ctr, pr);
            post(ppjs_pkg::K_ACTIVITY, serial_ctr, ppjs_pkg::ACT_PENDING, 1'b0);
            post(ppjs_pkg::K_ACCEPTED, serial_ctr, '0, 1'b0);
          end
        end
      end
      ppjs_pkg::OP_CANCEL: begin
        if (hit) begin
          post(ppjs_pkg::K_CANCEL, run_ser, '0, 1'b0);
        end else begin
          found = 1'b0;
          for (i = 0; i < q_len; i++) begin
            if (!found && q_ser[i] == js) begin
              found = 1'b1;
              queue_remove(i);
              post(ppjs_pkg::K_ACTIVITY, js, ppjs_pkg::ACT_FAILED, 1'b0);
            end
          end
        end
      end
      ppjs_pkg::OP_STATUS: begin
        if (hit) begin
          run_rerr = re;
          post(ppjs_pkg::K_STATUS, js, '0, re);
        end
      end
      ppjs_pkg::OP_ACTIVITY: begin
        if (hit) begin
          if (act >= ppjs_pkg::ACT_SUCCESS) begin
            if (run_rerr) begin
              // internal reset: same job goes to the server again
              post(ppjs_pkg::K_START, run_ser, '0, 1'b0);
            end else begin
              post(ppjs_pkg::K_ACTIVITY, run_ser,
                   run_reqd ? ppjs_pkg::ACT_PENDING : act, 1'b0);
              run_on   = 1'b0;
              run_reqd = 1'b0;
              if (q_len > 0) begin
                head_ser = q_ser[0];
                head_pri = q_pri[0];
                queue_remove(0);
                start_job(head_ser, head_pri);
                post(ppjs_pkg::K_START, head_ser, '0, 1'b0);
              end
            end
          end else begin
            post(ppjs_pkg::K_ACTIVITY, run_ser, act, 1'b0);
          end
        end
      end
      default: ;
    endcase
    if (due_notices.size() > first) begin
      due_notices[due_notices.size() - 1].fin = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request sender: bursts of random length, random gaps between them.
  // Valid stays high across back-to-back requests within a burst.
  // ---------------------------------------------------------------------------
  task automatic send_request(ppjs_pkg::op_t op, logic [1:0] pr, logic [31:0] js,
                              logic [1:0] act, logic re);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_valid     = 1'b1;
    opcode       = op;
    priority_req = pr;
    job_serial   = js;
    activity     = act;
    reset_error  = re;
    do @(posedge clk); while (!in_ready);
    predict_request(op, pr, js, act, re);
  endtask

  // Clears any reset flag, then completes jobs until the server is idle.
  task automatic retire_all_jobs();
    while (run_on) begin
      send_request(ppjs_pkg::OP_STATUS, 2'($urandom_range(0, 3)), run_ser,
                   2'($urandom_range(0, 3)), 1'b0);
      send_request(ppjs_pkg::OP_ACTIVITY, 2'($urandom_range(0, 3)), run_ser,
                   2'($urandom_range(ppjs_pkg::ACT_SUCCESS, ppjs_pkg::ACT_FAILED)),
                   1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Notice checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    notice_t exp;
    if (!rst && out_valid && out_ready) begin
      if (due_notices.size() == 0) begin
        $error("unexpected notice: kind %0d serial %0d", kind, out_serial);
        mismatches++;
      end else begin
        exp = due_notices.pop_front();
        if (kind !== exp.kind) begin
          $error("kind: expected %0d, got %0d", exp.kind, kind);
          mismatches++;
        end
        if (out_serial !== exp.serial) begin
          $error("out_serial: expected %0d, got %0d", exp.serial, out_serial);
          mismatches++;
        end
        if (out_activity !== exp.act) begin
          $error("out_activity: expected %0d, got %0d", exp.act, out_activity);
          mismatches++;
        end
        if (out_reset_error !== exp.rerr) begin
          $error("out_reset_error: expected %0d, got %0d", exp.rerr, out_reset_error);
          mismatches++;
        end
        if (last !== exp.fin) begin
          $error("last: expected %0d, got %0d", exp.fin, last);
          mismatches++;
        end
      end
    end
  end

  // Receiver: stretches of always-ready, light, heavy and near-total stalls.
  initial begin : rx_stall
    int ready_pct;
    int span;
    out_ready = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0:       ready_pct = 100;
        1:       ready_pct = 85;
        2:       ready_pct = 50;
        default: ready_pct = 15;
      endcase
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(negedge clk);
        out_ready = ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle start, reports on the running job, reset-flag restart.
  task automatic test_idle_and_reports();
    send_request(ppjs_pkg::OP_SUBMIT, PRIO_LOW, '0, '0, 1'b0);
    send_request(ppjs_pkg::OP_STATUS, PRIO_OVER, run_ser, ppjs_pkg::ACT_FAILED, 1'b1);
    send_request(ppjs_pkg::OP_ACTIVITY, PRIO_LOW, run_ser, ACT_RUNNING, 1'b0);
    send_request(ppjs_pkg::OP_ACTIVITY, ppjs_pkg::PRIO_HIGH, run_ser,
                 ppjs_pkg::ACT_PENDING, 1'b1);
    // completion while the reset flag is set restarts the same job
    send_request(ppjs_pkg::OP_ACTIVITY, PRIO_NORMAL, run_ser, ppjs_pkg::ACT_SUCCESS, 1'b0);
    send_request(ppjs_pkg::OP_ACTIVITY, PRIO_LOW, run_ser, ppjs_pkg::ACT_FAILED, 1'b0);
    send_request(ppjs_pkg::OP_STATUS, PRIO_LOW, run_ser, ppjs_pkg::ACT_PENDING, 1'b0);
  endtask

  // Preemption, repeated preemption, out-of-range priority, plain queueing.
  task automatic test_preemption();
    send_request(ppjs_pkg::OP_SUBMIT, PRIO_NORMAL, 32'hFFFF_FFFF, ppjs_pkg::ACT_FAILED, 1'b1);
    // second preemption: cancel again, no second queue entry
    send_request(ppjs_pkg::OP_SUBMIT, PRIO_OVER, '0, '0, 1'b0);
    send_request(ppjs_pkg::OP_SUBMIT, PRIO_LOW, $urandom(), 2'($urandom_range(0, 3)), 1'b1);
    // requeued job finishes: reported as pending, queue head starts
    send_request(ppjs_pkg::OP_ACTIVITY, PRIO_LOW, run_ser, ppjs_pkg::ACT_FAILED, 1'b0);
  endtask

  // Cancel of running, waiting and unknown jobs; reports with no match.
  task automatic test_cancel_and_unknown();
    send_request(ppjs_pkg::OP_CANCEL, ppjs_pkg::PRIO_HIGH, run_ser,
                 ppjs_pkg::ACT_SUCCESS, 1'b1);
    send_request(ppjs_pkg::OP_CANCEL, PRIO_LOW, q_ser[0], ppjs_pkg::ACT_PENDING, 1'b0);
    send_request(ppjs_pkg::OP_CANCEL, PRIO_OVER, 32'hFFFF_FFFF, ppjs_pkg::ACT_FAILED, 1'b1);
    send_request(ppjs_pkg::OP_STATUS, PRIO_LOW, 32'h0000_0000, '0, 1'b1);
    send_request(ppjs_pkg::OP_ACTIVITY, PRIO_LOW, 32'hFFFF_FFFF, ppjs_pkg::ACT_SUCCESS, 1'b0);
    send_request(ppjs_pkg::OP_ACTIVITY, PRIO_NORMAL, run_ser, ppjs_pkg::ACT_SUCCESS, 1'b0);
    send_request(ppjs_pkg::OP_ACTIVITY, PRIO_LOW, run_ser, ppjs_pkg::ACT_FAILED, 1'b0);
    send_request(ppjs_pkg::OP_ACTIVITY, PRIO_LOW, run_ser, ppjs_pkg::ACT_SUCCESS, 1'b0);
    // idle now: reports match nothing, then a high job starts at once
    send_request(ppjs_pkg::OP_ACTIVITY, PRIO_LOW, serial_ctr, ppjs_pkg::ACT_SUCCESS, 1'b0);
    send_request(ppjs_pkg::OP_CANCEL, PRIO_LOW, serial_ctr, ppjs_pkg::ACT_PENDING, 1'b0);
    send_request(ppjs_pkg::OP_SUBMIT, ppjs_pkg::PRIO_HIGH, $urandom(), ACT_RUNNING, 1'b0);
  endtask

  // Full queue: plain overflow and overflow caused by the preempted job.
  task automatic test_queue_full();
    retire_all_jobs();
    send_request(ppjs_pkg::OP_SUBMIT, PRIO_LOW, $urandom(), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)));
    repeat (QDEPTH - 1) begin
      send_request(ppjs_pkg::OP_SUBMIT, PRIO_LOW, $urandom(), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)));
    end
    send_request(ppjs_pkg::OP_SUBMIT, PRIO_NORMAL, $urandom(), '0, 1'b0);  // needs two slots
    send_request(ppjs_pkg::OP_SUBMIT, PRIO_LOW, $urandom(), '0, 1'b0);     // fills the last slot
    send_request(ppjs_pkg::OP_SUBMIT, PRIO_LOW, $urandom(), '0, 1'b0);
    send_request(ppjs_pkg::OP_SUBMIT, ppjs_pkg::PRIO_HIGH, $urandom(), '0, 1'b0);
    send_request(ppjs_pkg::OP_CANCEL, PRIO_LOW, q_ser[$urandom_range(0, q_len - 1)], '0, 1'b0);
    send_request(ppjs_pkg::OP_SUBMIT, ppjs_pkg::PRIO_HIGH, $urandom(), '0, 1'b0);  // one short
    send_request(ppjs_pkg::OP_CANCEL, PRIO_LOW, q_ser[$urandom_range(0, q_len - 1)], '0, 1'b0);
    send_request(ppjs_pkg::OP_SUBMIT, ppjs_pkg::PRIO_HIGH, $urandom(), '0, 1'b0);  // preempts
    send_request(ppjs_pkg::OP_SUBMIT, PRIO_OVER, $urandom(), '0, 1'b0);
    send_request(ppjs_pkg::OP_CANCEL, PRIO_LOW, q_ser[$urandom_range(0, q_len - 1)], '0, 1'b0);
    send_request(ppjs_pkg::OP_SUBMIT, PRIO_OVER, $urandom(), '0, 1'b0);    // already requeued
    retire_all_jobs();
  endtask

  // Mostly well-formed traffic against live jobs, plus some noise.
  task automatic test_random_traffic();
    int roll;
    int submit_pct;
    int pick;
    logic [31:0] target;
    repeat (RANDOM_REQS) begin
      roll       = $urandom_range(0, 99);
      submit_pct = (q_len < 8) ? 50 : 30;
      if (roll < 10) begin
        send_request(ppjs_pkg::op_t'(2'($urandom_range(0, 3))), 2'($urandom_range(0, 3)),
                     $urandom(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (roll < submit_pct || !run_on) begin
        send_request(ppjs_pkg::OP_SUBMIT, 2'($urandom_range(0, 3)), $urandom(),
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (roll < 62) begin
        send_request(ppjs_pkg::OP_STATUS, 2'($urandom_range(0, 3)), run_ser,
                     2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0));
      end else if (roll < 85) begin
        send_request(ppjs_pkg::OP_ACTIVITY, 2'($urandom_range(0, 3)), run_ser,
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else begin
        pick = $urandom_range(0, 3);
        if (pick == 0)      target = run_ser;
        else if (q_len > 0) target = q_ser[$urandom_range(0, q_len - 1)];
        else                target = $urandom();
        send_request(ppjs_pkg::OP_CANCEL, 2'($urandom_range(0, 3)), target,
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = ppjs_pkg::OP_SUBMIT;
    priority_req = PRIO_LOW;
    job_serial   = '0;
    activity     = ppjs_pkg::ACT_PENDING;
    reset_error  = 1'b0;
    q_len        = 0;
    run_on       = 1'b0;
    run_ser      = '0;
    run_pri      = PRIO_LOW;
    run_rerr     = 1'b0;
    run_reqd     = 1'b0;
    serial_ctr   = '0;
    mismatches   = 0;
    burst_left   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_and_reports();
    test_preemption();
    test_cancel_and_unknown();
    test_queue_full();
    test_random_traffic();

    // drain: every predicted notice in, then allow for a trailing queue walk
    @(negedge clk);
    in_valid = 1'b0;
    while (due_notices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** preemptive_priority_job_scheduler: PASSED **");
    end else begin
      $display("** preemptive_priority_job_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
